// ===== rtl/fmpd_pkg.sv =====
`timescale 1ns / 1ps

package fmpd_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int AUDIO_W    = 16;
	localparam int CFG_W      = 7;
	localparam int FACTOR_W   = 7;
	localparam int COUNT_W    = 6;
	localparam int FACTOR_MAX = 64;
	localparam int AUDIO_MAX  = 32767;
	localparam int ANGLE_W    = 32;
	localparam int ATAN_DEPTH = 24;
	localparam int ITER_W     = 5;

	localparam logic [FACTOR_W-1:0] DECIM_RESET  = 7'd15;
	localparam logic                ENABLE_RESET = 1'b1;

	// atan(2^-i) with a half turn at 2^31
	localparam logic [ANGLE_W-1:0] ATAN_TAB [ATAN_DEPTH] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef enum logic [0:0] {
		REG_DECIMATION = 1'b0,
		REG_ENABLE     = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_ROTATE = 4'b0010,
		ST_SCALE  = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	typedef struct packed {
		logic              load;
		logic              rotate;
		logic [ITER_W-1:0] iter;
		logic              scale;
		logic              emit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

// ===== rtl/fmpd_iq_if.sv =====
`timescale 1ns / 1ps

interface fmpd_iq_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [fmpd_pkg::SAMPLE_W-1:0] in_real;
	logic signed [fmpd_pkg::SAMPLE_W-1:0] in_imag;

	modport source (output valid, output in_real, output in_imag, input ready);
	modport sink (input valid, input in_real, input in_imag, output ready);
endinterface

// ===== rtl/fmpd_audio_if.sv =====
`timescale 1ns / 1ps

interface fmpd_audio_if;
	logic                                valid;
	logic                                ready;
	logic signed [fmpd_pkg::AUDIO_W-1:0] audio_sample;

	modport source (output valid, output audio_sample, input ready);
	modport sink (input valid, input audio_sample, output ready);
endinterface

// ===== rtl/fm_phase_discriminator.sv =====
`timescale 1ns / 1ps
// A kept sample is loaded into the CORDIC registers, rotated by the shared CORDIC stage that
// runs one rotation a cycle, scaled, then registered on the audio channel once it is free;
// no new sample is taken before then. While idle, dropped samples are taken one per cycle.
// Reset (arst_n low, asynchronous): decimation factor 15, demodulation on, decimation
// count and previous phase zero, output channel empty.
module fm_phase_discriminator #(
	parameter int SAMPLE_BITS   = 16,
	parameter int PHASE_BITS    = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [fmpd_pkg::CFG_W-1:0] cfg_data,
	fmpd_iq_if.sink                    iq,
	fmpd_audio_if.source               audio
);

	fmpd_pkg::cmd_t    cmd;
	fmpd_pkg::status_t status;
	logic              in_ready;

	assign iq.ready = in_ready;

	fmpd_ctrl #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (iq.valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.status   (status)
	);

	fmpd_datapath #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.PHASE_BITS (PHASE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_real     (iq.in_real),
		.in_imag     (iq.in_imag),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (audio.valid),
		.out_ready   (audio.ready),
		.audio_sample(audio.audio_sample)
	);

endmodule

// ===== rtl/fmpd_ctrl.sv =====
`timescale 1ns / 1ps

module fmpd_ctrl #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [0:0]                     cfg_index,
	input  logic [fmpd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	output fmpd_pkg::cmd_t                 cmd,
	input  fmpd_pkg::status_t              status
);

	localparam logic [fmpd_pkg::ITER_W-1:0] LAST_ITER =
		fmpd_pkg::ITER_W'(CORDIC_STAGES - 1);

	fmpd_pkg::state_t                    state_q;
	logic [fmpd_pkg::ITER_W-1:0]         iter_q;
	logic [fmpd_pkg::FACTOR_W-1:0]       factor_q;
	logic                                enable_q;
	logic [fmpd_pkg::COUNT_W-1:0]        count_q;
	logic [fmpd_pkg::FACTOR_W-1:0]       factor_eff;
	logic [fmpd_pkg::FACTOR_W-1:0]       count_cur;
	logic [fmpd_pkg::FACTOR_W-1:0]       count_nxt;
	logic                                accept;
	logic                                keep;

	assign in_ready = (state_q == fmpd_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready && enable_q;

	always_comb begin
		if (factor_q == '0) begin
			factor_eff = fmpd_pkg::FACTOR_W'(1);
		end else if (factor_q > fmpd_pkg::FACTOR_W'(fmpd_pkg::FACTOR_MAX)) begin
			factor_eff = fmpd_pkg::FACTOR_W'(fmpd_pkg::FACTOR_MAX);
		end else begin
			factor_eff = factor_q;
		end
		// restart the count if the factor shrank to or below it
		count_cur = (fmpd_pkg::FACTOR_W'(count_q) >= factor_eff) ? '0
			: fmpd_pkg::FACTOR_W'(count_q);
		keep      = (count_cur == '0);
		count_nxt = count_cur + fmpd_pkg::FACTOR_W'(1);
		if (count_nxt >= factor_eff) begin
			count_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= fmpd_pkg::DECIM_RESET;
			enable_q <= fmpd_pkg::ENABLE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == fmpd_pkg::REG_DECIMATION) begin
				factor_q <= cfg_data;
			end else begin
				enable_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fmpd_pkg::ST_IDLE;
			iter_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				fmpd_pkg::ST_IDLE: begin
					iter_q <= '0;
					if (accept) begin
						count_q <= count_nxt[fmpd_pkg::COUNT_W-1:0];
						if (keep) begin
							state_q <= fmpd_pkg::ST_ROTATE;
						end
					end
				end
				fmpd_pkg::ST_ROTATE: begin
					iter_q <= iter_q + fmpd_pkg::ITER_W'(1);
					if (iter_q == LAST_ITER) begin
						state_q <= fmpd_pkg::ST_SCALE;
					end
				end
				fmpd_pkg::ST_SCALE: begin
					state_q <= fmpd_pkg::ST_EMIT;
				end
				fmpd_pkg::ST_EMIT: begin
					// hold until the output register can take the result
					if (status.out_free) begin
						state_q <= fmpd_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= fmpd_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd.load   = accept && keep;
		cmd.rotate = (state_q == fmpd_pkg::ST_ROTATE);
		cmd.iter   = iter_q;
		cmd.scale  = (state_q == fmpd_pkg::ST_SCALE);
		cmd.emit   = (state_q == fmpd_pkg::ST_EMIT);
	end

endmodule

// ===== rtl/fmpd_datapath.sv =====
`timescale 1ns / 1ps

module fmpd_datapath #(
	parameter int SAMPLE_BITS = 16,
	parameter int PHASE_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic signed [fmpd_pkg::SAMPLE_W-1:0] in_real,
	input  logic signed [fmpd_pkg::SAMPLE_W-1:0] in_imag,
	input  fmpd_pkg::cmd_t                       cmd,
	output fmpd_pkg::status_t                    status,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [fmpd_pkg::AUDIO_W-1:0]  audio_sample
);

	localparam int W      = SAMPLE_BITS + 2;
	localparam int PROD_W = PHASE_BITS + 17;
	localparam logic [fmpd_pkg::ANGLE_W-1:0] PHASE_RND =
		fmpd_pkg::ANGLE_W'(1) << (31 - PHASE_BITS);
	localparam logic [fmpd_pkg::ANGLE_W-1:0] HALF_TURN = 32'h80000000;
	localparam logic [PHASE_BITS-2:0] HALF_LSB = (PHASE_BITS - 1)'(1) << (PHASE_BITS - 2);
	localparam logic signed [PROD_W-1:0] AMAX = PROD_W'(fmpd_pkg::AUDIO_MAX);
	localparam logic signed [PROD_W-1:0] AMIN = -AMAX;

	logic [SAMPLE_BITS-1:0]          re_raw;
	logic [SAMPLE_BITS-1:0]          im_raw;
	logic signed [W-1:0]             re_ext;
	logic signed [W-1:0]             im_ext;
	logic signed [W-1:0]             x_q;
	logic signed [W-1:0]             y_q;
	logic [fmpd_pkg::ANGLE_W-1:0]    z_q;
	logic                            zero_q;
	logic signed [W-1:0]             xs;
	logic signed [W-1:0]             ys;
	logic [fmpd_pkg::ANGLE_W-1:0]    z_rnd;
	logic [PHASE_BITS-1:0]           cur_phase;
	logic [PHASE_BITS-1:0]           prev_phase_q;
	logic [PHASE_BITS-1:0]           diff;
	logic signed [PROD_W-1:0]        prod_q;
	logic signed [PROD_W-1:0]        q_floor;
	logic signed [PROD_W-1:0]        q_rnd;
	logic [PHASE_BITS-2:0]           rem;
	logic                            round_up;
	logic signed [fmpd_pkg::AUDIO_W-1:0] audio_nxt;
	logic                            out_valid_q;
	logic signed [fmpd_pkg::AUDIO_W-1:0] audio_q;

	assign re_raw = SAMPLE_BITS'($unsigned(in_real));
	assign im_raw = SAMPLE_BITS'($unsigned(in_imag));
	assign re_ext = W'($signed(re_raw));
	assign im_ext = W'($signed(im_raw));

	assign xs = x_q >>> cmd.iter;
	assign ys = y_q >>> cmd.iter;

	// CORDIC vectoring: x takes the imaginary part, y the real part
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			zero_q <= (re_ext == '0) && (im_ext == '0);
			if (im_ext < 0) begin
				x_q <= -im_ext;
				y_q <= -re_ext;
				z_q <= HALF_TURN;
			end else begin
				x_q <= im_ext;
				y_q <= re_ext;
				z_q <= '0;
			end
		end else if (cmd.rotate) begin
			if (!y_q[W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + fmpd_pkg::ATAN_TAB[cmd.iter];
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - fmpd_pkg::ATAN_TAB[cmd.iter];
			end
		end
	end

	assign z_rnd     = z_q + PHASE_RND;
	assign cur_phase = zero_q ? '0 : z_rnd[fmpd_pkg::ANGLE_W-1 -: PHASE_BITS];
	assign diff      = prev_phase_q - cur_phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_phase_q <= '0;
		end else if (cmd.scale) begin
			prev_phase_q <= cur_phase;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			prod_q <= PROD_W'($signed(diff)) * AMAX;
		end
	end

	// round half to even, then clamp
	always_comb begin
		q_floor  = prod_q >>> (PHASE_BITS - 1);
		rem      = prod_q[PHASE_BITS-2:0];
		round_up = (rem > HALF_LSB) || ((rem == HALF_LSB) && q_floor[0]);
		q_rnd    = q_floor + PROD_W'(round_up);
		if (q_rnd > AMAX) begin
			audio_nxt = fmpd_pkg::AUDIO_W'(AMAX);
		end else if (q_rnd < AMIN) begin
			audio_nxt = fmpd_pkg::AUDIO_W'(AMIN);
		end else begin
			audio_nxt = fmpd_pkg::AUDIO_W'(q_rnd);
		end
	end

	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit && status.out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && status.out_free) begin
			audio_q <= audio_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign audio_sample = audio_q;

endmodule
